/* hdl/hmd_pkg.sv */
// Shared types and constants of the hold-and-modify pixel decoder.
// Standalone package: no dependencies.
package hmd_pkg;

    localparam int COLOR_REGS = 256;
    localparam int CREG_AW    = (COLOR_REGS > 1) ? $clog2(COLOR_REGS) : 1;
    localparam int RGB_W      = 24;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LOCT  = 2'd2,
        MODE_LINE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_HAM8    = 2'd0,
        CFG_AGA     = 2'd1,
        CFG_EHB     = 2'd2,
        CFG_BRD_SPR = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HAM_RELOAD = 2'd0,
        HAM_BLUE   = 2'd1,
        HAM_RED    = 2'd2,
        HAM_GREEN  = 2'd3
    } t_ham_ctl;

    localparam logic [8:0] PAL_DBG_RED_D0 = 9'd289;
    localparam logic [8:0] PAL_DBG_RED_A0 = 9'd290;
    localparam logic [8:0] PAL_DBG_RED_90 = 9'd291;

    localparam logic [RGB_W-1:0] RGB_DBG_RED_D0 = 24'hD00000;
    localparam logic [RGB_W-1:0] RGB_DBG_RED_A0 = 24'hA00000;
    localparam logic [RGB_W-1:0] RGB_DBG_RED_90 = 24'h900000;
    localparam logic [RGB_W-1:0] RGB_HIGH_NIBS  = 24'hF0F0F0;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  reg_number;
        logic [11:0] reg_value;
        logic        border_valid;
        logic [8:0]  border_index;
        logic [7:0]  raw_planes;
        logic [7:0]  color_index;
        logic        sprite_in_zbuf;
        logic        sprite_visible;
        logic [7:0]  sprite_index;
    } t_in_item;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

endpackage

/* hdl/hold_and_modify_pixel_decoder.sv */
// Hold-and-modify pixel decoder: color register file, hold color, border/sprite/HAM paths.
// Depends on hmd_pkg and hmd_ram.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_in_item | item in
//  out      | o_out_valid, i_out_ready, o_out_item | result out
//  cfg      | i_cfg_we, i_cfg_idx, i_cfg_data  | register write
//
// One item per cycle while the output is not stalled: first the two copies of the color
// file are read (one for the hold reload, one for the palette lookup), then the hold color
// is modified, written back and the output register loaded.
// Reset (synchronous, active low) clears config, hold color, control and the 256 per-entry
// valid bits, so unwritten entries read as zero; no clearing pass.
// A stalled output holds the second stage, and the input stalls only when both are full.
module hold_and_modify_pixel_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hmd_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hmd_pkg::t_out_item o_out_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic              i_cfg_data
);

    localparam int AW = hmd_pkg::CREG_AW;
    localparam int RW = hmd_pkg::RGB_W;
    localparam int COLOR_REGS_N = hmd_pkg::COLOR_REGS;

    // configuration
    logic r_ham8;
    logic r_aga;
    logic r_ehb;
    logic r_brd_spr;

    // stage one (read issued) and output registers
    logic                  r_s1_v;
    hmd_pkg::t_in_item     r_s1_item;
    logic [8:0]            r_pal_idx;
    logic                  r_a_ok;
    logic                  r_b_ok;
    logic                  r_fwd_a;
    logic                  r_fwd_b;
    logic [RW-1:0]         r_fwd_data;
    logic [RW-1:0]         r_hold;
    logic [RW-1:0]         n_hold;
    logic                  r_out_v;
    hmd_pkg::t_out_item    r_out;
    logic [COLOR_REGS_N-1:0] r_cvalid;

    logic          in_xfer;
    logic          s1_adv;
    logic [7:0]    addr_a;
    logic [7:0]    addr_b;
    logic [8:0]    pal_idx;
    logic          a_in_range;
    logic          b_in_range;
    logic [RW-1:0] ram_a;
    logic [RW-1:0] ram_b;
    logic [RW-1:0] rd_a;
    logic [RW-1:0] rd_b;
    logic [RW-1:0] pal_rgb;
    logic [RW-1:0] pix;
    logic          pix_valid;
    logic          wr_en;
    logic [7:0]    wr_addr;
    logic [RW-1:0] wr_data;
    logic [3:0]    nib_r;
    logic [3:0]    nib_g;
    logic [3:0]    nib_b;
    logic [7:0]    ham6_d;

    assign s1_adv     = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_s1_v || !r_out_v || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // ---------------- stage zero: address decode ----------------
    always_comb begin
        pal_idx = {1'b0, i_in_item.sprite_index};
        if (i_in_item.border_valid && !(r_brd_spr && i_in_item.sprite_in_zbuf)) begin
            pal_idx = i_in_item.border_index;
        end
        addr_b = pal_idx[7:0];
        // entries 32..63 mirror 0..31 unless they are registers of their own
        if (pal_idx[8:5] == 4'b0001 && (r_ehb || !r_aga)) begin
            addr_b[5] = 1'b0;
        end

        unique case (i_in_item.mode)
            hmd_pkg::MODE_PIXEL: begin
                if (i_in_item.border_valid) begin
                    addr_a = i_in_item.border_index[7:0];
                end else if (r_ham8) begin
                    addr_a = {2'b00, i_in_item.color_index[7:2]};
                end else begin
                    addr_a = {4'h0, i_in_item.color_index[3:0]};
                end
            end
            hmd_pkg::MODE_WRITE: addr_a = i_in_item.reg_number;
            hmd_pkg::MODE_LOCT:  addr_a = i_in_item.reg_number;
            hmd_pkg::MODE_LINE:  addr_a = '0;
            default:             addr_a = '0;
        endcase
    end

    assign a_in_range = (32'(addr_a) < COLOR_REGS_N);
    assign b_in_range = (32'(addr_b) < COLOR_REGS_N);

    hmd_ram #(.WIDTH(RW), .DEPTH(COLOR_REGS_N)) u_ram_hold (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (in_xfer),
        .i_raddr (addr_a[AW-1:0]),
        .o_rdata (ram_a)
    );

    hmd_ram #(.WIDTH(RW), .DEPTH(COLOR_REGS_N)) u_ram_pal (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (in_xfer),
        .i_raddr (addr_b[AW-1:0]),
        .o_rdata (ram_b)
    );

    // ---------------- stage one: modify and write back ----------------
    assign rd_a = r_fwd_a ? r_fwd_data : (r_a_ok ? ram_a : '0);
    assign rd_b = r_fwd_b ? r_fwd_data : (r_b_ok ? ram_b : '0);

    assign nib_r  = r_s1_item.reg_value[11:8];
    assign nib_g  = r_s1_item.reg_value[7:4];
    assign nib_b  = r_s1_item.reg_value[3:0];
    assign ham6_d = r_aga ? {r_s1_item.color_index[3:0], r_s1_item.color_index[3:0]}
                          : {r_s1_item.color_index[3:0], 4'h0};

    always_comb begin
        if (r_pal_idx[8]) begin
            unique case (r_pal_idx)
                hmd_pkg::PAL_DBG_RED_D0: pal_rgb = hmd_pkg::RGB_DBG_RED_D0;
                hmd_pkg::PAL_DBG_RED_A0: pal_rgb = hmd_pkg::RGB_DBG_RED_A0;
                hmd_pkg::PAL_DBG_RED_90: pal_rgb = hmd_pkg::RGB_DBG_RED_90;
                default:                 pal_rgb = '0;
            endcase
        end else if (r_pal_idx[8:5] == 4'b0001 && r_ehb) begin
            // half-bright copy
            pal_rgb = {1'b0, rd_b[23:17], 1'b0, rd_b[15:9], 1'b0, rd_b[7:1]};
        end else begin
            pal_rgb = rd_b;
        end
    end

    always_comb begin
        wr_addr = r_s1_item.reg_number;
        wr_en   = 1'b0;
        wr_data = '0;
        unique case (r_s1_item.mode)
            hmd_pkg::MODE_WRITE: begin
                wr_en   = 1'b1;
                wr_data = r_aga ? {nib_r, nib_r, nib_g, nib_g, nib_b, nib_b}
                                : {nib_r, 4'h0, nib_g, 4'h0, nib_b, 4'h0};
            end
            hmd_pkg::MODE_LOCT: begin
                wr_en   = 1'b1;
                wr_data = (rd_a & hmd_pkg::RGB_HIGH_NIBS) | {4'h0, nib_r, 4'h0, nib_g, 4'h0, nib_b};
            end
            default: ;
        endcase
        wr_en = wr_en && s1_adv && (32'(wr_addr) < COLOR_REGS_N);
    end

    always_comb begin
        n_hold    = r_hold;
        pix       = '0;
        pix_valid = 1'b0;
        unique case (r_s1_item.mode)
            hmd_pkg::MODE_LINE: n_hold = rd_a;
            hmd_pkg::MODE_PIXEL: begin
                pix_valid = 1'b1;
                if (r_s1_item.border_valid) begin
                    pix = pal_rgb;
                    if (!(r_brd_spr && r_s1_item.sprite_in_zbuf) &&
                        !r_s1_item.border_index[8]) begin
                        n_hold = rd_a;
                    end
                end else begin
                    if (r_ham8) begin
                        unique case (hmd_pkg::t_ham_ctl'(r_s1_item.raw_planes[1:0]))
                            hmd_pkg::HAM_RELOAD: n_hold = rd_a;
                            hmd_pkg::HAM_BLUE:   n_hold[7:2]   = r_s1_item.color_index[7:2];
                            hmd_pkg::HAM_RED:    n_hold[23:18] = r_s1_item.color_index[7:2];
                            hmd_pkg::HAM_GREEN:  n_hold[15:10] = r_s1_item.color_index[7:2];
                            default:             n_hold = r_hold;
                        endcase
                    end else begin
                        unique case (hmd_pkg::t_ham_ctl'(r_s1_item.raw_planes[5:4]))
                            hmd_pkg::HAM_RELOAD: n_hold = rd_a;
                            hmd_pkg::HAM_BLUE:   n_hold[7:0]   = ham6_d;
                            hmd_pkg::HAM_RED:    n_hold[23:16] = ham6_d;
                            hmd_pkg::HAM_GREEN:  n_hold[15:8]  = ham6_d;
                            default:             n_hold = r_hold;
                        endcase
                    end
                    pix = r_s1_item.sprite_visible ? pal_rgb : n_hold;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ham8    <= 1'b0;
            r_aga     <= 1'b0;
            r_ehb     <= 1'b0;
            r_brd_spr <= 1'b0;
            r_s1_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_hold    <= '0;
            r_cvalid  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hmd_pkg::CFG_HAM8:    r_ham8    <= i_cfg_data;
                    hmd_pkg::CFG_AGA:     r_aga     <= i_cfg_data;
                    hmd_pkg::CFG_EHB:     r_ehb     <= i_cfg_data;
                    hmd_pkg::CFG_BRD_SPR: r_brd_spr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
                r_hold  <= n_hold;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (wr_en) begin
                r_cvalid[wr_addr[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item  <= i_in_item;
            r_pal_idx  <= pal_idx;
            r_a_ok     <= a_in_range && r_cvalid[addr_a[AW-1:0]];
            r_b_ok     <= b_in_range && r_cvalid[addr_b[AW-1:0]];
            // forward the write that lands at this same edge
            r_fwd_a    <= wr_en && (wr_addr == addr_a);
            r_fwd_b    <= wr_en && (wr_addr == addr_b);
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out <= '{pixel_valid: pix_valid,
                       red:         pix[23:16],
                       green:       pix[15:8],
                       blue:        pix[7:0]};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_cvalid[$past(wr_addr[AW-1:0])])
        else $error("written entry not marked valid");

    a_fwd_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && wr_en && (wr_addr == addr_a) |=> r_fwd_a)
        else $error("write-back hit not forwarded");

    a_nonpixel_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.pixel_valid |->
            r_out.red == 8'h00 && r_out.green == 8'h00 && r_out.blue == 8'h00)
        else $error("non-pixel result carries color");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v && $stable(r_s1_item))
        else $error("stalled item lost");

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_hold))
        else $error("hold color changed without an advancing item");

endmodule

/* hdl/hmd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
